>>> rtl/laser_triangulation_range_assert.svh
// ============================================================================
// laser_triangulation_range_assert.svh
// Assertion macros used by the checker file of the range block.
// ============================================================================
`ifndef LASER_TRIANGULATION_RANGE_ASSERT_SVH
`define LASER_TRIANGULATION_RANGE_ASSERT_SVH

// Property checked at every clock edge, switched off while reset is high
`define LTR_ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked at every clock edge, reset included
`define LTR_ASSERT_ALW(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/ltr_pkg.sv
// ============================================================================
// ltr_pkg
// Constants, types and helper functions of the laser triangulation range block.
// ============================================================================
package ltr_pkg;

   // Triangulation constants in fixed point
   localparam logic [55:0] A_Q46     = 56'd49124420310427238;
   localparam logic [32:0] B_Q30     = 33'd4675071902;
   localparam logic [16:0] C_Q24     = 17'd115964;
   localparam logic [26:0] F_Q24     = 27'd117121745;
   localparam logic [26:0] K_Q30     = 27'd90827708;
   localparam logic [21:0] R_Q16     = 22'd3224371;
   localparam logic [19:0] RANGE_MAX = 20'hFFFFF;

   // Reciprocal of F for the tangent: t = (ym * ceil(2^80 / F)) >> 56.
   // Exact floor while ym * F < 2^56, which covers every row width.
   localparam int           T_SH        = 56;
   localparam logic [80:0]  T_POW       = 81'd1 << 80;
   localparam logic [53:0]  T_RECIP     = 54'((T_POW + 81'(F_Q24) - 81'd1) / 81'(F_Q24));
   localparam logic [26:0]  T_RECIP_HI  = T_RECIP[53:27];
   localparam logic [26:0]  T_RECIP_LO  = T_RECIP[26:0];

   // Datapath sizes
   localparam int IMG_W      = 11;
   localparam int Q_W        = 32;
   localparam int SQRT_IN_W  = 64;
   localparam int SQRT_OUT_W = SQRT_IN_W / 2;
   localparam int CORDIC_N   = 17;
   localparam int CORDIC_W   = 36;
   localparam int ANG_W      = 19;

   localparam logic signed [ANG_W-1:0] DEG18_Q16 = 19'sd20589;

   // Pipeline stage numbers (stage 1 is loaded at the accepting edge)
   localparam int S_DIV       = 2 + Q_W;
   localparam int S_SEC       = S_DIV + 2 + SQRT_OUT_W;
   localparam int S_SUM       = S_SEC + 4;
   localparam int S_DIST      = S_SUM + SQRT_OUT_W;
   localparam int LTR_LATENCY = S_DIST + 1;

   typedef struct packed {
      logic den_pos;
      logic q_ovf;
   } ltr_flags_type;

   // atan(2^-i) in Q.16
   function automatic logic signed [ANG_W-1:0] atan_q16(input logic [4:0] idx);
      logic signed [ANG_W-1:0] val;
      case (idx)
         5'd0:    val = 19'sd51472;
         5'd1:    val = 19'sd30386;
         5'd2:    val = 19'sd16055;
         5'd3:    val = 19'sd8150;
         5'd4:    val = 19'sd4091;
         5'd5:    val = 19'sd2047;
         5'd6:    val = 19'sd1024;
         5'd7:    val = 19'sd512;
         5'd8:    val = 19'sd256;
         5'd9:    val = 19'sd128;
         5'd10:   val = 19'sd64;
         5'd11:   val = 19'sd32;
         5'd12:   val = 19'sd16;
         5'd13:   val = 19'sd8;
         5'd14:   val = 19'sd4;
         5'd15:   val = 19'sd2;
         5'd16:   val = 19'sd1;
         default: val = 19'sd0;
      endcase
      return val;
   endfunction

   // Q.16 to Q.14, rounded half away from zero, kept to 16 bits
   function automatic logic [15:0] q16_to_q14(input logic signed [ANG_W-1:0] v);
      logic signed [ANG_W:0] ve;
      logic [ANG_W:0]        mag;
      logic [ANG_W:0]        rnd;
      logic [ANG_W:0]        res;
      ve  = (ANG_W+1)'(v);
      mag = ve[ANG_W] ? (ANG_W+1)'(-ve) : (ANG_W+1)'(ve);
      rnd = (mag + (ANG_W+1)'(2)) >> 2;
      res = ve[ANG_W] ? (ANG_W+1)'(-rnd) : rnd;
      return res[15:0];
   endfunction

endpackage

>>> rtl/ltr_delay.sv
// ============================================================================
// ltr_delay
// Fixed-length shift line that keeps side data aligned with the pipeline.
// ============================================================================
module ltr_delay #(
   parameter int W     = 1,
   parameter int DEPTH = 1
) (
   input  logic         clock,
   input  logic [W-1:0] d,
   output logic [W-1:0] q
);

   generate
      if (DEPTH == 0) begin : g_none
         assign q = d;
      end else begin : g_line
         logic [W-1:0] sh_ff [DEPTH];

         // shift one stage per clock
         always_ff @(posedge clock) begin
            sh_ff[0] <= d;
            for (int k = 1; k < DEPTH; k++) begin
               sh_ff[k] <= sh_ff[k-1];
            end
         end

         assign q = sh_ff[DEPTH-1];
      end
   endgenerate

endmodule

>>> rtl/ltr_udiv.sv
// ============================================================================
// ltr_udiv
// Pipelined restoring divider, one quotient bit per stage, with an overflow
// flag for quotients that do not fit in QUO_W bits.
// ============================================================================
module ltr_udiv #(
   parameter int NUM_W = 56,
   parameter int DEN_W = 33,
   parameter int QUO_W = 32
) (
   input  logic             clock,
   input  logic [NUM_W-1:0] num,
   input  logic [DEN_W-1:0] den,
   output logic [QUO_W-1:0] quo,
   output logic             ovf
);

   localparam int REM_W = DEN_W + QUO_W;

   logic [REM_W-1:0] rem_ff [QUO_W];
   logic [DEN_W-1:0] den_ff [QUO_W];
   logic [QUO_W-1:0] quo_ff [QUO_W];
   logic             ovf_ff [QUO_W];

   logic [REM_W-1:0] num_ext;
   logic             ovf_in;

   // quotient too large when num >= den * 2^QUO_W
   assign num_ext = REM_W'(num);
   assign ovf_in  = num_ext >= {den, {QUO_W{1'b0}}};

   generate
      for (genvar k = 0; k < QUO_W; k++) begin : g_stage
         localparam int SH = QUO_W - 1 - k;
         logic [REM_W-1:0] rem_in;
         logic [DEN_W-1:0] den_in;
         logic [QUO_W-1:0] quo_in;
         logic             ovf_s_in;
         logic [REM_W:0]   diff;

         if (k == 0) begin : g_first
            assign rem_in   = num_ext;
            assign den_in   = den;
            assign quo_in   = '0;
            assign ovf_s_in = ovf_in;
         end else begin : g_next
            assign rem_in   = rem_ff[k-1];
            assign den_in   = den_ff[k-1];
            assign quo_in   = quo_ff[k-1];
            assign ovf_s_in = ovf_ff[k-1];
         end

         // trial subtract of the shifted divisor
         assign diff = {1'b0, rem_in} - ({{(QUO_W+1){1'b0}}, den_in} << SH);

         always_ff @(posedge clock) begin
            rem_ff[k] <= diff[REM_W] ? rem_in : diff[REM_W-1:0];
            den_ff[k] <= den_in;
            quo_ff[k] <= {quo_in[QUO_W-2:0], ~diff[REM_W]};
            ovf_ff[k] <= ovf_s_in;
         end
      end
   endgenerate

   assign quo = quo_ff[QUO_W-1];
   assign ovf = ovf_ff[QUO_W-1];

endmodule

>>> rtl/ltr_isqrt.sv
// ============================================================================
// ltr_isqrt
// Pipelined floor square root, one root bit per stage.
// ============================================================================
module ltr_isqrt #(
   parameter int IN_W = 64
) (
   input  logic                clock,
   input  logic [IN_W-1:0]     rad,
   output logic [IN_W/2-1:0]   root
);

   localparam int OUT_W = IN_W / 2;
   localparam int REM_W = OUT_W + 2;

   logic [REM_W-1:0] rem_ff  [OUT_W];
   logic [OUT_W-1:0] root_ff [OUT_W];
   logic [IN_W-1:0]  rad_ff  [OUT_W];

   generate
      for (genvar k = 0; k < OUT_W; k++) begin : g_stage
         logic [REM_W-1:0] rem_in;
         logic [OUT_W-1:0] root_in;
         logic [IN_W-1:0]  rad_in;
         logic [REM_W-1:0] rem_sh;
         logic [REM_W:0]   diff;

         if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = rad;
         end else begin : g_next
            assign rem_in  = rem_ff[k-1];
            assign root_in = root_ff[k-1];
            assign rad_in  = rad_ff[k-1];
         end

         // bring down two radicand bits, try root*4+1
         assign rem_sh = {rem_in[OUT_W-1:0], rad_in[IN_W-1 -: 2]};
         assign diff   = {1'b0, rem_sh} - {1'b0, root_in, 2'b01};

         always_ff @(posedge clock) begin
            rem_ff[k]  <= diff[REM_W] ? rem_sh : diff[REM_W-1:0];
            root_ff[k] <= {root_in[OUT_W-2:0], ~diff[REM_W]};
            rad_ff[k]  <= rad_in << 2;
         end
      end
   endgenerate

   assign root = root_ff[OUT_W-1];

endmodule

>>> rtl/ltr_cordic.sv
// ============================================================================
// ltr_cordic
// Pipelined CORDIC in vectoring mode: returns the angle of (x, y) in Q.16.
// ============================================================================
module ltr_cordic import ltr_pkg::*; #(
   parameter int W = 36
) (
   input  logic                    clock,
   input  logic signed [W-1:0]     x,
   input  logic signed [W-1:0]     y,
   output logic signed [ANG_W-1:0] z
);

   logic signed [W-1:0]     x_ff [CORDIC_N];
   logic signed [W-1:0]     y_ff [CORDIC_N];
   logic signed [ANG_W-1:0] z_ff [CORDIC_N];

   generate
      for (genvar k = 0; k < CORDIC_N; k++) begin : g_stage
         logic signed [W-1:0]     x_in;
         logic signed [W-1:0]     y_in;
         logic signed [ANG_W-1:0] z_in;
         logic signed [W-1:0]     xs;
         logic signed [W-1:0]     ys;
         logic signed [ANG_W-1:0] ang;

         if (k == 0) begin : g_first
            assign x_in = x;
            assign y_in = y;
            assign z_in = '0;
         end else begin : g_next
            assign x_in = x_ff[k-1];
            assign y_in = y_ff[k-1];
            assign z_in = z_ff[k-1];
         end

         assign xs  = x_in >>> k;
         assign ys  = y_in >>> k;
         assign ang = atan_q16(5'(k));

         // rotate toward the x axis
         always_ff @(posedge clock) begin
            if (y_in[W-1]) begin
               x_ff[k] <= x_in - ys;
               y_ff[k] <= y_in + xs;
               z_ff[k] <= z_in - ang;
            end else begin
               x_ff[k] <= x_in + ys;
               y_ff[k] <= y_in - xs;
               z_ff[k] <= z_in + ang;
            end
         end
      end
   endgenerate

   assign z = z_ff[CORDIC_N-1];

endmodule

>>> rtl/laser_triangulation_range.sv
// ============================================================================
// laser_triangulation_range
// Laser triangulation rangefinder: spot column and row in, distance, yaw and
// pitch out, fully pipelined.
// ============================================================================
// One request enters per clock while busy is low. Its result is driven on the
// rsp_ ports by the output registers, strobed by rsp_valid for one cycle; the
// receiver cannot stall, so busy is high only during reset. The latency is set
// by three bit-per-stage units in series: the 32-stage divider for the centre
// depth, the 32-stage square root for the secant and the 32-stage square root
// for the distance. csr_ready is always high; write the image height only while
// no request is in flight.
module laser_triangulation_range import ltr_pkg::*; #(
   parameter int ROW_BITS = 10
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [15:0]         req_spot_column,
   input  logic [ROW_BITS-1:0] req_row_index,
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic [IMG_W-1:0]    csr_data,
   output logic                rsp_valid,
   output logic [19:0]         rsp_range_value,
   output logic signed [15:0]  rsp_yaw_value,
   output logic signed [15:0]  rsp_pitch_value,
   output logic                rsp_status
);

   localparam int DYM_W  = (ROW_BITS > 10) ? ROW_BITS : 10;
   localparam int DY_W   = DYM_W + 1;
   localparam int YM_W   = DYM_W + 17;
   localparam int T_W    = YM_W - 2;
   localparam int S_YAW  = S_DIV + 4 + CORDIC_N;
   localparam int S_PIT  = 3 + CORDIC_N;

   // ---------------------------------------------------------------- control
   logic [IMG_W-1:0]       image_height_ff;
   logic [LTR_LATENCY-1:0] vld_ff;
   logic                   accept;

   assign busy      = reset;
   assign csr_ready = 1'b1;
   assign accept    = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         image_height_ff <= 11'd480;
      end else if (csr_valid && csr_ready) begin
         image_height_ff <= csr_data;
      end
   end

   // valid bit travels with each request
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[LTR_LATENCY-2:0], accept};
      end
   end

   // ---------------------------------------------------------------- stage 1
   logic [32:0]             cprod;
   logic [9:0]              center;
   logic signed [34:0]      den_s1_ff;
   logic signed [DY_W-1:0]  dy_s1_ff;

   assign cprod  = 33'(C_Q24) * 33'(req_spot_column);
   assign center = image_height_ff[IMG_W-1:1];

   always_ff @(posedge clock) begin
      den_s1_ff <= $signed({2'b00, B_Q30}) - $signed({2'b00, cprod});
      dy_s1_ff  <= $signed({1'b0, DYM_W'(req_row_index)}) - $signed({1'b0, DYM_W'(center)});
   end

   // ---------------------------------------------------------------- stage 2
   logic [DYM_W-1:0]  dym;
   logic [55:0]       numq_s2_ff;
   logic [32:0]       d_s2_ff;
   logic              dpos_s2_ff;
   logic [YM_W-1:0]   ym_s2_ff;
   logic              ysgn_s2_ff;

   assign dym = DYM_W'(dy_s1_ff[DY_W-1] ? -dy_s1_ff : dy_s1_ff);

   always_ff @(posedge clock) begin
      numq_s2_ff <= A_Q46 + 56'(den_s1_ff[32:1]);
      d_s2_ff    <= den_s1_ff[32:0];
      dpos_s2_ff <= ~den_s1_ff[34] && (den_s1_ff != '0);
      ym_s2_ff   <= YM_W'(dym) * YM_W'(C_Q24);
      ysgn_s2_ff <= dy_s1_ff[DY_W-1];
   end

   // ------------------------------------------------------ pitch angle path
   logic signed [CORDIC_W-1:0] ym_ext;
   logic signed [CORDIC_W-1:0] pit_y;
   logic signed [ANG_W-1:0]    zpit;
   logic [15:0]                pitch_ff;
   logic [15:0]                pitch_end;

   assign ym_ext = $signed(CORDIC_W'(ym_s2_ff));
   assign pit_y  = ysgn_s2_ff ? -ym_ext : ym_ext;

   ltr_cordic #(.W(CORDIC_W)) u_pit_cordic (
      .clock (clock),
      .x     ($signed(CORDIC_W'(F_Q24))),
      .y     (pit_y),
      .z     (zpit)
   );

   always_ff @(posedge clock) begin
      pitch_ff <= q16_to_q14(zpit - DEG18_Q16);
   end

   ltr_delay #(.W(16), .DEPTH(S_DIST - S_PIT)) u_pit_dly (
      .clock (clock), .d (pitch_ff), .q (pitch_end)
   );

   // ------------------------------------------------------ divider for q
   logic [Q_W-1:0]   qraw;
   logic             qovf;
   logic             dpos_div;

   ltr_udiv #(.NUM_W(56), .DEN_W(33), .QUO_W(Q_W)) u_qdiv (
      .clock (clock), .num (numq_s2_ff), .den (d_s2_ff), .quo (qraw), .ovf (qovf)
   );

   ltr_delay #(.W(1), .DEPTH(Q_W)) u_dpos_dly (
      .clock (clock), .d (dpos_s2_ff), .q (dpos_div)
   );

   // ------------------------------------- tangent by reciprocal multiply
   logic [YM_W+26:0] tph_ff;
   logic [YM_W+26:0] tpl_ff;
   logic [YM_W+53:0] tsum;
   logic [T_W-1:0]   t4_ff;
   logic [T_W-1:0]   t_div;

   assign tsum = {tph_ff, 27'd0} + (YM_W+54)'(tpl_ff);

   always_ff @(posedge clock) begin
      tph_ff <= (YM_W+27)'(ym_s2_ff) * (YM_W+27)'(T_RECIP_HI);
      tpl_ff <= (YM_W+27)'(ym_s2_ff) * (YM_W+27)'(T_RECIP_LO);
      t4_ff  <= T_W'(tsum >> T_SH);
   end

   ltr_delay #(.W(T_W), .DEPTH(Q_W - 2)) u_t_dly (
      .clock (clock), .d (t4_ff), .q (t_div)
   );

   // --------------------------------------------------------------- stage 35
   logic [Q_W-1:0]     q35_ff;
   ltr_flags_type      flags35_ff;
   logic [2*T_W-1:0]   tt35_ff;

   always_ff @(posedge clock) begin
      q35_ff             <= qovf ? '1 : qraw;
      flags35_ff.den_pos <= dpos_div;
      flags35_ff.q_ovf   <= qovf;
      tt35_ff            <= (2*T_W)'(t_div) * (2*T_W)'(t_div);
   end

   // --------------------------------------------------------------- stage 36
   logic [63:0]      sec2;
   logic [63:0]      sqin36_ff;
   logic [58:0]      kp36_ff;
   logic [Q_W-1:0]   q36_ff;

   assign sec2 = 64'(tt35_ff >> 20) + (64'd1 << 28);

   always_ff @(posedge clock) begin
      sqin36_ff <= sec2 << 28;
      kp36_ff   <= 59'(q35_ff) * 59'(K_Q30);
      q36_ff    <= q35_ff;
   end

   // --------------------------------------------------------------- stage 37
   logic [29:0]         lq;
   logic signed [31:0]  e37_ff;
   logic [Q_W-1:0]      q37_ff;

   assign lq = 30'((kp36_ff + (59'd1 << 29)) >> 30);

   always_ff @(posedge clock) begin
      e37_ff <= $signed(32'(R_Q16)) - $signed(32'(lq));
      q37_ff <= q36_ff;
   end

   // ---------------------------------------------------------- secant root
   logic [SQRT_OUT_W-1:0] sec;

   ltr_isqrt #(.IN_W(SQRT_IN_W)) u_sec_sqrt (
      .clock (clock), .rad (sqin36_ff), .root (sec)
   );

   // --------------------------------------------------------- yaw angle path
   logic signed [ANG_W-1:0] zyaw;
   logic [15:0]             yaw_ff;
   logic [15:0]             yaw_end;

   ltr_cordic #(.W(CORDIC_W)) u_yaw_cordic (
      .clock (clock),
      .x     ($signed(CORDIC_W'(q37_ff))),
      .y     (CORDIC_W'(e37_ff)),
      .z     (zyaw)
   );

   always_ff @(posedge clock) begin
      yaw_ff <= q16_to_q14(zyaw);
   end

   ltr_delay #(.W(16), .DEPTH(S_DIST - S_YAW)) u_yaw_dly (
      .clock (clock), .d (yaw_ff), .q (yaw_end)
   );

   // align q with the secant and e with the pd product
   logic [Q_W-1:0]     q_sec;
   logic signed [31:0] e_sec;

   ltr_delay #(.W(Q_W), .DEPTH(S_SEC - (S_DIV + 3))) u_q_dly (
      .clock (clock), .d (q37_ff), .q (q_sec)
   );

   ltr_delay #(.W(32), .DEPTH(S_SEC + 1 - (S_DIV + 3))) u_e_dly (
      .clock (clock), .d (e37_ff), .q (e_sec)
   );

   // ----------------------------------------------------- pd and the squares
   logic [63:0]  pdp69_ff;
   logic [31:0]  emag;
   logic         pdok70_ff;
   logic [27:0]  pm70_ff;
   logic [27:0]  em70_ff;
   logic [55:0]  em2_ff;
   logic [55:0]  pm2_ff;
   logic [63:0]  ssum_ff;

   assign emag = e_sec[31] ? 32'(-e_sec) : 32'(e_sec);

   always_ff @(posedge clock) begin
      pdp69_ff  <= 64'(q_sec) * 64'(sec);
      pdok70_ff <= (pdp69_ff[63:60] == 4'd0);
      pm70_ff   <= pdp69_ff[59:32];
      em70_ff   <= emag[31:4];
      em2_ff    <= 56'(em70_ff) * 56'(em70_ff);
      pm2_ff    <= 56'(pm70_ff) * 56'(pm70_ff);
      ssum_ff   <= 64'(em2_ff) + 64'(pm2_ff);
   end

   // -------------------------------------------------------- distance root
   logic [SQRT_OUT_W-1:0] d12;

   ltr_isqrt #(.IN_W(SQRT_IN_W)) u_dist_sqrt (
      .clock (clock), .rad (ssum_ff), .root (d12)
   );

   ltr_flags_type flags_end;
   logic          pdok_end;

   ltr_delay #(.W($bits(ltr_flags_type)), .DEPTH(S_DIST - (S_DIV + 1))) u_flag_dly (
      .clock (clock), .d (flags35_ff), .q (flags_end)
   );

   ltr_delay #(.W(1), .DEPTH(S_DIST - (S_SEC + 2))) u_pdok_dly (
      .clock (clock), .d (pdok70_ff), .q (pdok_end)
   );

   // ---------------------------------------------------------- output stage
   logic [SQRT_OUT_W:0] d4;
   logic                st;

   assign d4 = (SQRT_OUT_W+1)'((33'(d12) + 33'd128) >> 8);
   assign st = ~flags_end.den_pos | flags_end.q_ovf | ~pdok_end
               | (d4 > (SQRT_OUT_W+1)'(RANGE_MAX));

   always_ff @(posedge clock) begin
      rsp_range_value <= st ? RANGE_MAX : d4[19:0];
      rsp_yaw_value   <= flags_end.den_pos ? $signed(yaw_end) : 16'sd0;
      rsp_pitch_value <= $signed(pitch_end);
      rsp_status      <= st;
   end

   assign rsp_valid = vld_ff[LTR_LATENCY-1];

endmodule

>>> rtl/laser_triangulation_range_chk.sv
// ============================================================================
// laser_triangulation_range_chk
// Port-level checker for the range block, bound to the top level.
// ============================================================================
`include "laser_triangulation_range_assert.svh"

module laser_triangulation_range_chk import ltr_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic        rsp_status,
   input logic [19:0] rsp_range_value
);

   // every accepted request gives a result after the fixed latency
   `LTR_ASSERT_RST(a_result_follows, clock, reset, (start && !busy) |-> ##LTR_LATENCY rsp_valid, "accepted request produced no result")

   // no result without a request accepted the latency before
   `LTR_ASSERT_RST(a_no_spurious, clock, reset, rsp_valid |-> $past(start && !busy, LTR_LATENCY), "result without a request")

   // a flagged result always carries the saturated distance
   `LTR_ASSERT_ALW(a_status_range, clock, (rsp_valid && rsp_status) |-> (rsp_range_value == RANGE_MAX), "status set but range not saturated")

endmodule

bind laser_triangulation_range laser_triangulation_range_chk u_chk (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_status      (rsp_status),
   .rsp_range_value (rsp_range_value)
);
